// File: rtl/sawr_pkg.sv
// Package for the stop-and-wait receiver: codes, field widths and constants.
package sawr_pkg;

	// Datagram header and payload limits
	localparam int unsigned HDR_BYTES   = 13;
	localparam int unsigned MAX_PAYLOAD = 8192;

	// Field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned OP_W     = 8;
	localparam int unsigned SEQ_W    = 64;
	localparam int unsigned LEN_W    = 32;
	localparam int unsigned BYTES_W  = 16;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CNT_W    = 8;

	// Register port
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_RETRY_LIMIT = 1'b0;   // word index of retry_limit
	localparam logic [CNT_W-1:0] RETRY_LIMIT_RESET = 8'd50;

	// Message type bytes
	localparam logic [OP_W-1:0] OP_SIZE = 8'h53;   // 'S'
	localparam logic [OP_W-1:0] OP_DATA = 8'h44;   // 'D'
	localparam logic [OP_W-1:0] OP_ERR  = 8'h45;   // 'E'

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_DGRAM   = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_FATAL   = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		SEND_NONE = 2'd0,
		SEND_REQ  = 2'd1,
		SEND_ACK  = 2'd2
	} send_kind_t;

	localparam logic [STATUS_W-1:0] ST_IDLE = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WAIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RECV = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DONE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FAIL = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_WAIT = 5'b00010,
		PH_RECV = 5'b00100,
		PH_DONE = 5'b01000,
		PH_FAIL = 5'b10000
	} phase_t;

	function automatic logic [STATUS_W-1:0] phase_status(phase_t ph);
		logic [STATUS_W-1:0] st;
		unique case (ph)
			PH_IDLE: st = ST_IDLE;
			PH_WAIT: st = ST_WAIT;
			PH_RECV: st = ST_RECV;
			PH_DONE: st = ST_DONE;
			PH_FAIL: st = ST_FAIL;
			default: st = ST_IDLE;
		endcase
		return st;
	endfunction

	// Header length check: too short, too long, or length fields disagree
	function automatic logic malformed(logic [LEN_W-1:0] len, logic [BYTES_W-1:0] nbytes,
			logic [LEN_W-1:0] max_len);
		logic [LEN_W:0] expect_bytes;
		expect_bytes = {1'b0, len} + (LEN_W+1)'(HDR_BYTES);
		return (nbytes < BYTES_W'(HDR_BYTES))
			|| (len > max_len)
			|| ({{(LEN_W+1-BYTES_W){1'b0}}, nbytes} != expect_bytes);
	endfunction

endpackage

// File: rtl/stop_and_wait_receiver.sv
// Stop-and-wait receiver: header-level transfer control with an APB register port.
// Pipeline: an item is registered in stage 1 at the input, and its result in the result
//   register, which drives out_valid, once that register is empty or being taken.
// Throughput: one item per cycle while out_stall is low; a held result stalls the input
//   once stage 1 also holds an item (two items wait inside at most).
// Reset: arst_n clears control state, phase goes idle, counts go to zero and
//   retry_limit returns to 50.
module stop_and_wait_receiver #(
	parameter int unsigned MAX_PAYLOAD = sawr_pkg::MAX_PAYLOAD
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sawr_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [sawr_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [sawr_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// input items
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sawr_pkg::CMD_W-1:0]          cmd,
	input  logic [sawr_pkg::OP_W-1:0]           msg_op,
	input  logic [sawr_pkg::SEQ_W-1:0]          msg_seq,
	input  logic [sawr_pkg::LEN_W-1:0]          msg_len,
	input  logic [sawr_pkg::BYTES_W-1:0]        rx_bytes,
	// result items
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sawr_pkg::KIND_W-1:0]         send_kind,
	output logic [sawr_pkg::SEQ_W-1:0]          send_number,
	output logic                                write_payload,
	output logic [sawr_pkg::STATUS_W-1:0]       status,
	output logic [sawr_pkg::SEQ_W-1:0]          bytes_received
);

	// ---------------------------------------------------------------------
	// Register port: one register, retry_limit, at word 0.
	// ---------------------------------------------------------------------
	logic [sawr_pkg::CNT_W-1:0] retry_limit_q;
	logic                       cfg_wr;
	logic                       cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == sawr_pkg::REG_RETRY_LIMIT);
	assign cfg_wr  = psel && penable && pwrite && cfg_hit;
	assign prdata  = cfg_hit ? {{(sawr_pkg::APB_DATA_W-sawr_pkg::CNT_W){1'b0}}, retry_limit_q}
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= sawr_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_wr) begin
			retry_limit_q <= pwdata[sawr_pkg::CNT_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Handshake. Stage 1 holds the accepted item; it moves into the result
	// register whenever that register is empty or being taken. The input
	// stalls only while stage 1 holds an item that cannot move on.
	// ---------------------------------------------------------------------
	logic                           valid_s1;
	sawr_pkg::cmd_t                 cmd_s1;
	logic [sawr_pkg::OP_W-1:0]      op_s1;
	logic [sawr_pkg::SEQ_W-1:0]     seq_s1;
	logic [sawr_pkg::LEN_W-1:0]     len_s1;
	logic [sawr_pkg::BYTES_W-1:0]   bytes_s1;

	logic out_valid_q;
	logic advance;      // result register can take a new item
	logic step;         // item in stage 1 commits this cycle
	logic load_s1;

	assign advance   = !out_valid_q || !out_stall;
	assign step      = valid_s1 && advance;
	assign load_s1   = !valid_s1 || advance;
	assign in_stall  = !load_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cmd_s1   <= sawr_pkg::cmd_t'(cmd);
			op_s1    <= msg_op;
			seq_s1   <= msg_seq;
			len_s1   <= msg_len;
			bytes_s1 <= rx_bytes;
		end
	end

	// ---------------------------------------------------------------------
	// Transfer state
	// ---------------------------------------------------------------------
	sawr_pkg::phase_t              phase_q, phase_d;
	logic [sawr_pkg::SEQ_W-1:0]    total_q, total_d;
	logic [sawr_pkg::SEQ_W-1:0]    count_q, count_d;
	logic [sawr_pkg::SEQ_W-1:0]    expect_q, expect_d;
	logic [sawr_pkg::CNT_W-1:0]    idle_q, idle_d;
	logic [sawr_pkg::CNT_W-1:0]    tries_q, tries_d;

	sawr_pkg::send_kind_t          kind_d;
	logic [sawr_pkg::SEQ_W-1:0]    num_d;
	logic                          wr_d;

	// Data block checks. A block that fits never overshoots the total, so the
	// transfer is complete exactly when it fills the remaining space.
	logic                          bad_hdr;
	logic [sawr_pkg::SEQ_W-1:0]    remaining;
	logic [sawr_pkg::SEQ_W-1:0]    len_ext;
	logic                          fits;
	logic                          fills;

	assign bad_hdr   = sawr_pkg::malformed(len_s1, bytes_s1, sawr_pkg::LEN_W'(MAX_PAYLOAD));
	assign remaining = total_q - count_q;
	assign len_ext   = {{(sawr_pkg::SEQ_W-sawr_pkg::LEN_W){1'b0}}, len_s1};
	assign fits      = (len_ext <= remaining);
	assign fills     = (len_ext == remaining);

	always_comb begin
		phase_d  = phase_q;
		total_d  = total_q;
		count_d  = count_q;
		expect_d = expect_q;
		idle_d   = idle_q;
		tries_d  = tries_q;
		kind_d   = sawr_pkg::SEND_NONE;
		num_d    = '0;
		wr_d     = 1'b0;

		if (cmd_s1 == sawr_pkg::CMD_START) begin
			// start abandons anything in progress
			total_d  = '0;
			count_d  = '0;
			expect_d = '0;
			idle_d   = '0;
			if (retry_limit_q == '0) begin
				tries_d = '0;
				phase_d = sawr_pkg::PH_FAIL;
			end else begin
				tries_d = sawr_pkg::CNT_W'(1);
				phase_d = sawr_pkg::PH_WAIT;
				kind_d  = sawr_pkg::SEND_REQ;
			end
		end else begin
			unique case (phase_q)
				sawr_pkg::PH_WAIT: begin
					unique case (cmd_s1)
						sawr_pkg::CMD_FATAL: phase_d = sawr_pkg::PH_FAIL;
						sawr_pkg::CMD_TIMEOUT: begin
							if (tries_q >= retry_limit_q) begin
								phase_d = sawr_pkg::PH_FAIL;
							end else begin
								tries_d = tries_q + sawr_pkg::CNT_W'(1);
								kind_d  = sawr_pkg::SEND_REQ;
							end
						end
						sawr_pkg::CMD_DGRAM: begin
							if (bad_hdr || op_s1 == sawr_pkg::OP_ERR) begin
								phase_d = sawr_pkg::PH_FAIL;
							end else if (op_s1 == sawr_pkg::OP_SIZE) begin
								total_d = seq_s1;
								kind_d  = sawr_pkg::SEND_ACK;
								num_d   = seq_s1;
								// empty file completes on the size reply
								phase_d = (seq_s1 == '0) ? sawr_pkg::PH_DONE
								                         : sawr_pkg::PH_RECV;
							end
						end
						default: ;
					endcase
				end
				sawr_pkg::PH_RECV: begin
					unique case (cmd_s1)
						sawr_pkg::CMD_FATAL: phase_d = sawr_pkg::PH_FAIL;
						sawr_pkg::CMD_TIMEOUT: begin
							if (idle_q >= retry_limit_q) begin
								phase_d = sawr_pkg::PH_FAIL;
							end else begin
								idle_d = idle_q + sawr_pkg::CNT_W'(1);
							end
						end
						sawr_pkg::CMD_DGRAM: begin
							if (bad_hdr) begin
								phase_d = sawr_pkg::PH_FAIL;
							end else begin
								// any well-formed datagram counts as activity
								idle_d = '0;
								if (op_s1 == sawr_pkg::OP_SIZE) begin
									kind_d = sawr_pkg::SEND_ACK;
									num_d  = seq_s1;
								end else if (op_s1 == sawr_pkg::OP_DATA) begin
									if (seq_s1 == expect_q && fits) begin
										count_d  = count_q + len_ext;
										wr_d     = 1'b1;
										kind_d   = sawr_pkg::SEND_ACK;
										num_d    = seq_s1;
										expect_d = expect_q + sawr_pkg::SEQ_W'(1);
										if (fills) begin
											phase_d = sawr_pkg::PH_DONE;
										end
									end else if (seq_s1 < expect_q) begin
										// duplicate of an older block
										kind_d = sawr_pkg::SEND_ACK;
										num_d  = seq_s1;
									end
								end
							end
						end
						default: ;
					endcase
				end
				default: ;   // idle, done, failed: only start acts
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sawr_pkg::PH_IDLE;
			total_q  <= '0;
			count_q  <= '0;
			expect_q <= '0;
			idle_q   <= '0;
			tries_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			total_q  <= total_d;
			count_q  <= count_d;
			expect_q <= expect_d;
			idle_q   <= idle_d;
			tries_q  <= tries_d;
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	logic [sawr_pkg::KIND_W-1:0]   kind_q;
	logic [sawr_pkg::SEQ_W-1:0]    num_q;
	logic                          wr_q;
	logic [sawr_pkg::STATUS_W-1:0] status_q;
	logic [sawr_pkg::SEQ_W-1:0]    rcvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q   <= kind_d;
			num_q    <= num_d;
			wr_q     <= wr_d;
			status_q <= sawr_pkg::phase_status(phase_d);
			rcvd_q   <= count_d;
		end
	end

	assign send_kind      = kind_q;
	assign send_number    = num_q;
	assign write_payload  = wr_q;
	assign status         = status_q;
	assign bytes_received = rcvd_q;

endmodule

// File: test/testbench.sv
// Testbench for the stop-and-wait receiver: random and directed headers against a predictor.
`timescale 1ns / 1ps

module testbench;
	import sawr_pkg::*;

	// One decoded datagram header or event, as it goes into the block
	typedef struct {
		cmd_t               cmd;
		logic [OP_W-1:0]    op;
		logic [SEQ_W-1:0]   seq;
		logic [LEN_W-1:0]   len;
		logic [BYTES_W-1:0] nbytes;
	} header_t;

	// What the block answers for one item
	typedef struct {
		send_kind_t          kind;
		logic [SEQ_W-1:0]    number;
		logic                wr;
		logic [STATUS_W-1:0] status;
		logic [SEQ_W-1:0]    count;
	} reply_t;

	localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_RETRY_LIMIT, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      cmd = '0;
	logic [OP_W-1:0]       msg_op = '0;
	logic [SEQ_W-1:0]      msg_seq = '0;
	logic [LEN_W-1:0]      msg_len = '0;
	logic [BYTES_W-1:0]    rx_bytes = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KIND_W-1:0]     send_kind;
	logic [SEQ_W-1:0]      send_number;
	logic                  write_payload;
	logic [STATUS_W-1:0]   status;
	logic [SEQ_W-1:0]      bytes_received;

	stop_and_wait_receiver uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.msg_op         (msg_op),
		.msg_seq        (msg_seq),
		.msg_len        (msg_len),
		.rx_bytes       (rx_bytes),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_kind      (send_kind),
		.send_number    (send_number),
		.write_payload  (write_payload),
		.status         (status),
		.bytes_received (bytes_received)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stimulus and expectations
	header_t headers_to_send[$];
	reply_t  pending_replies[$];
	header_t on_wire;
	int      sender_idle_pct = 0;
	int      stall_pct = 0;
	int      errors = 0;

	// Predicted transfer state
	logic [7:0]          retry_limit_now = RETRY_LIMIT_RESET;
	logic [STATUS_W-1:0] xfer_phase = ST_IDLE;
	logic [SEQ_W-1:0]    xfer_total = '0;
	logic [SEQ_W-1:0]    xfer_got = '0;
	logic [SEQ_W-1:0]    xfer_block = '0;
	logic [7:0]          idle_timeouts = '0;
	logic [7:0]          size_requests = '0;

	task automatic flag_error(input string msg);
		if (errors < 100)
			$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Header is unusable: shorter than a header, payload too long, or lengths disagree
	function automatic logic bad_header(logic [LEN_W-1:0] len, logic [BYTES_W-1:0] nbytes);
		return (nbytes < BYTES_W'(HDR_BYTES)) || (len > LEN_W'(MAX_PAYLOAD))
			|| (64'(nbytes) != 64'(len) + 64'(HDR_BYTES));
	endfunction

	// Advances the predicted transfer by one item and returns the answer it implies
	function automatic reply_t advance_transfer(header_t h);
		reply_t r;
		r.kind = SEND_NONE;
		r.number = '0;
		r.wr = 1'b0;
		if (h.cmd == CMD_START) begin
			xfer_total = '0;
			xfer_got = '0;
			xfer_block = '0;
			idle_timeouts = '0;
			if (retry_limit_now == 8'd0) begin
				size_requests = '0;
				xfer_phase = ST_FAIL;
			end else begin
				size_requests = 8'd1;
				xfer_phase = ST_WAIT;
				r.kind = SEND_REQ;
			end
		end else if (xfer_phase == ST_WAIT) begin
			if (h.cmd == CMD_FATAL)
				xfer_phase = ST_FAIL;
			else if (h.cmd == CMD_TIMEOUT) begin
				if (size_requests >= retry_limit_now)
					xfer_phase = ST_FAIL;
				else begin
					size_requests++;
					r.kind = SEND_REQ;
				end
			end else if (bad_header(h.len, h.nbytes) || h.op == OP_ERR)
				xfer_phase = ST_FAIL;
			else if (h.op == OP_SIZE) begin
				xfer_total = h.seq;
				r.kind = SEND_ACK;
				r.number = h.seq;
				xfer_phase = (h.seq == '0) ? ST_DONE : ST_RECV;
			end
		end else if (xfer_phase == ST_RECV) begin
			if (h.cmd == CMD_FATAL)
				xfer_phase = ST_FAIL;
			else if (h.cmd == CMD_TIMEOUT) begin
				if (idle_timeouts >= retry_limit_now)
					xfer_phase = ST_FAIL;
				else
					idle_timeouts++;
			end else if (bad_header(h.len, h.nbytes))
				xfer_phase = ST_FAIL;
			else begin
				// any well-formed datagram counts as activity
				idle_timeouts = '0;
				if (h.op == OP_SIZE) begin
					r.kind = SEND_ACK;
					r.number = h.seq;
				end else if (h.op == OP_DATA) begin
					if (h.seq == xfer_block && 64'(h.len) <= xfer_total - xfer_got) begin
						xfer_got = xfer_got + 64'(h.len);
						r.wr = 1'b1;
						r.kind = SEND_ACK;
						r.number = h.seq;
						xfer_block++;
						if (xfer_got >= xfer_total)
							xfer_phase = ST_DONE;
					end else if (h.seq < xfer_block) begin
						// stale block: our earlier ack was lost
						r.kind = SEND_ACK;
						r.number = h.seq;
					end
				end
			end
		end
		r.status = xfer_phase;
		r.count = xfer_got;
		return r;
	endfunction

	// Driver: presents queued items, with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_replies.push_back(advance_transfer(on_wire));
			if (!in_valid || !in_stall) begin
				if (headers_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					on_wire = headers_to_send.pop_front();
					in_valid <= 1'b1;
					cmd <= on_wire.cmd;
					msg_op <= on_wire.op;
					msg_seq <= on_wire.seq;
					msg_len <= on_wire.len;
					rx_bytes <= on_wire.nbytes;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Monitor: random stalls, compares each answer with the oldest expectation
	always @(posedge clk) begin : monitor
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_replies.size() == 0)
					flag_error("answer with nothing expected");
				else begin
					want = pending_replies.pop_front();
					check_field("send_kind", 64'(send_kind), 64'(want.kind));
					check_field("send_number", send_number, want.number);
					check_field("write_payload", 64'(write_payload), 64'(want.wr));
					check_field("status", 64'(status), 64'(want.status));
					check_field("bytes_received", bytes_received, want.count);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic push(input cmd_t c, input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len, input logic [BYTES_W-1:0] nbytes);
		header_t h;
		h.cmd = c;
		h.op = op;
		h.seq = seq;
		h.len = len;
		h.nbytes = nbytes;
		headers_to_send.push_back(h);
	endtask

	// Well-formed datagram: length fields agree
	task automatic push_ok(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
			input logic [LEN_W-1:0] len);
		push(CMD_DGRAM, op, seq, len, BYTES_W'(HDR_BYTES + len));
	endtask

	// Event with random header fields, which the block should not look at
	task automatic push_event(input cmd_t c);
		push(c, OP_W'($urandom), {$urandom, $urandom}, $urandom, BYTES_W'($urandom));
	endtask

	task automatic queue_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				push(cmd_t'($urandom_range(0, 3)), OP_W'($urandom), {$urandom, $urandom},
					$urandom, BYTES_W'($urandom));
			else
				push_ok($urandom_range(0, 2) == 0 ? OP_W'($urandom) : OP_DATA,
					{$urandom, $urandom}, $urandom_range(0, MAX_PAYLOAD + 2));
		end
	endtask

	// One transfer: start, size exchange, blocks, with occasional faults mixed in
	task automatic queue_transfer();
		longint unsigned size, left, blk;
		int n, len, cap;
		push_event(CMD_START);
		n = ($urandom_range(0, 7) == 0) ? int'(retry_limit_now) : $urandom_range(0, 2);
		repeat (n) push_event(CMD_TIMEOUT);
		case ($urandom_range(0, 15))
			0: begin
				push_event(CMD_FATAL);
				return;
			end
			1: begin
				push_ok(OP_ERR, {$urandom, $urandom}, $urandom_range(0, 16));
				return;
			end
			2: begin
				push(CMD_DGRAM, OP_SIZE, $urandom_range(1, 99), $urandom_range(0, 20), 16'd12);
				return;
			end
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: size = 0;
			1: size = {$urandom, $urandom};
			2, 3: size = $urandom_range(1, 64);
			default: size = $urandom_range(1, 20000);
		endcase
		push_ok(OP_SIZE, size, 0);
		left = size;
		blk = 0;
		for (int k = 0; k < 16 && left != 0; k++) begin
			cap = (left < MAX_PAYLOAD) ? int'(left) : MAX_PAYLOAD;
			case ($urandom_range(0, 19))
				0: if (blk != 0)
					push_ok(OP_DATA, $urandom_range(0, int'(blk) - 1), $urandom_range(0, cap));
				1: push_ok(OP_SIZE, size, 0);
				2: begin
					n = ($urandom_range(0, 3) == 0) ? int'(retry_limit_now) + 1
						: $urandom_range(1, 3);
					repeat (n) push_event(CMD_TIMEOUT);
				end
				3: push_ok(OP_DATA, ($urandom_range(0, 1) == 0) ? blk + 1 + $urandom_range(0, 3)
					: {$urandom, $urandom}, $urandom_range(0, cap));
				4: if (cap < MAX_PAYLOAD)
					push_ok(OP_DATA, blk, cap + 1);
				5: push_ok(OP_W'($urandom), blk, $urandom_range(0, 32));
				6: begin
					len = $urandom_range(0, cap);
					push(CMD_DGRAM, OP_DATA, blk, len, BYTES_W'(HDR_BYTES + len + 1));
					return;
				end
				7: begin
					push_event(CMD_FATAL);
					return;
				end
				default: begin
					len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
					push_ok(OP_DATA, blk, len);
					left -= len;
					blk++;
				end
			endcase
		end
	endtask

	task automatic queue_random(input int n);
		int target;
		target = headers_to_send.size() + n;
		while (headers_to_send.size() < target) begin
			if ($urandom_range(0, 6) == 0)
				queue_noise();
			else
				queue_transfer();
		end
	endtask

	// Directed cases across the field checks and phases, starting from the reset limit
	task automatic queue_directed();
		push(CMD_TIMEOUT, 8'hFF, '1, '1, '1);         // ignored while idle, all bits set
		push_ok(OP_SIZE, 64'd5, 0);                     // ignored while idle
		push(CMD_FATAL, 8'h00, '0, '0, '0);
		push(CMD_START, 8'hFF, '1, '1, '1);             // size request
		push_event(CMD_TIMEOUT);                        // resend request
		push_ok(8'h00, '0, 0);                          // unknown type while waiting
		push_ok(OP_SIZE, '0, 0);                        // empty file
		push_ok(OP_DATA, '0, 0);                        // ignored when done
		push_event(CMD_START);
		push_ok(OP_SIZE, 64'd20, 0);
		push_ok(OP_DATA, 64'd0, 8);
		push_ok(OP_DATA, 64'd0, 4);                     // stale block
		push_ok(OP_DATA, 64'd5, 4);                     // block from the future
		push_ok(OP_DATA, 64'd1, 13);                    // overruns the size
		push_ok(OP_SIZE, 64'd20, 0);                    // size repeated
		push_ok(8'hAA, 64'd1, 3);                       // unknown type while receiving
		push_event(CMD_TIMEOUT);
		push_ok(OP_DATA, 64'd1, 12);                    // completes the transfer
		push_event(CMD_START);
		push_ok(OP_SIZE, '1, 0);                        // largest size
		push_ok(OP_DATA, 64'd0, MAX_PAYLOAD);           // largest payload
		push(CMD_DGRAM, OP_DATA, 64'd1, 32'd8, 16'd12); // shorter than a header
		push_event(CMD_START);
		push_ok(OP_ERR, '0, 0);                         // error reply
		push_event(CMD_START);
		push(CMD_DGRAM, OP_SIZE, 64'd9, MAX_PAYLOAD + 1, 16'(HDR_BYTES + MAX_PAYLOAD + 1));
	endtask

	task automatic write_retry_limit(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		retry_limit_now = value;
	endtask

	// Sender holds back until every answer is in
	task automatic drain();
		while (headers_to_send.size() != 0 || in_valid || pending_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_directed();
		drain();

		write_retry_limit(8'd0);
		sender_idle_pct = 34;
		stall_pct = 34;
		push_event(CMD_START);
		push_event(CMD_TIMEOUT);
		push_ok(OP_SIZE, 64'd3, 0);
		queue_random(30);
		drain();

		write_retry_limit(8'd1);
		sender_idle_pct = 67;
		stall_pct = 0;
		queue_random(200);
		drain();

		write_retry_limit(8'd255);
		sender_idle_pct = 0;
		stall_pct = 67;
		queue_random(220);
		drain();

		write_retry_limit(8'($urandom_range(2, 20)));
		sender_idle_pct = 34;
		stall_pct = 34;
		queue_random(150);
		drain();
		sender_idle_pct = 0;
		stall_pct = 0;
		queue_random(150);
		drain();

		repeat (8) @(posedge clk);
		if (pending_replies.size() != 0)
			flag_error($sformatf("%0d answers never arrived", pending_replies.size()));
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
